>>> rtl/core/slot_allocator_with_kind_queues_core_defines.svh
// Assertion macros shared by the slot allocator RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef SLOT_ALLOCATOR_WITH_KIND_QUEUES_CORE_DEFINES_SVH
`define SLOT_ALLOCATOR_WITH_KIND_QUEUES_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SAKQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SAKQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SAKQ_ASSERT(lbl, prop, msg)
`define SAKQ_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> rtl/core/sakq_pkg.sv
// Package for the slot allocator: payload structs, codes and default sizes.
// Used by every module of the slot allocator core except sakq_ram.
`default_nettype none

package sakq_pkg;

  localparam int MAX_SLOTS_DEF = 8;
  localparam int KINDS_DEF     = 3;
  localparam int CFG_W         = 4;
  localparam int SLOT_OUT_W    = 3;
  localparam int COUNT_OUT_W   = 4;

  typedef enum logic [0:0] {
    CMD_ADD = 1'b0,
    CMD_USE = 1'b1
  } cmd_e;

  localparam logic [1:0] KIND_REUSABLE = 2'd0;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] kind;
    logic       front_exhausted;
  } in_t;

  typedef struct packed {
    logic                   ok;
    logic [SLOT_OUT_W-1:0]  slot;
    logic                   slot_freed;
    logic [COUNT_OUT_W-1:0] free_count;
  } out_t;

  typedef struct packed {
    logic take;
    logic give_back;
  } fm_op_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_op_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/sakq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module sakq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sakq_free_map.sv
// Free map of the slots with first-free search and free count.
// Depends on sakq_pkg.
`default_nettype none

module sakq_free_map #(
  parameter int MAX_SLOTS = sakq_pkg::MAX_SLOTS_DEF,
  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [CNT_W-1:0]    n_active_i,
  input  wire sakq_pkg::fm_op_t    op_i,
  input  wire logic [SLOT_W-1:0]   give_slot_i,
  output logic                     found_o,
  output logic      [SLOT_W-1:0]   first_slot_o,
  output logic      [CNT_W-1:0]    free_count_o
);

  logic [MAX_SLOTS-1:0] free_map_q, free_map_d;
  logic [MAX_SLOTS-1:0] avail;
  logic [CNT_W-1:0]     count_now;
  logic                 give_counted;

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      avail[i] = free_map_q[i] && (CNT_W'(i) < n_active_i);
    end
  end

  always_comb begin
    first_slot_o = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        first_slot_o = SLOT_W'(i);
      end
    end
  end

  assign found_o = |avail;

  always_comb begin
    count_now = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      count_now = count_now + CNT_W'(avail[i]);
    end
  end

  assign give_counted = op_i.give_back && (CNT_W'(give_slot_i) < n_active_i);
  assign free_count_o = count_now - CNT_W'(op_i.take) + CNT_W'(give_counted);

  always_comb begin
    free_map_d = free_map_q;
    if (op_i.take) begin
      free_map_d[first_slot_o] = 1'b0;
    end
    if (op_i.give_back) begin
      free_map_d[give_slot_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_map_q <= '1;
    end else begin
      free_map_q <= free_map_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sakq_queues.sv
// Per-kind FIFO queues of slot indices kept in one shared RAM, with pointers.
// Depends on sakq_pkg and sakq_ram.
`default_nettype none

module sakq_queues #(
  parameter int MAX_SLOTS = sakq_pkg::MAX_SLOTS_DEF,
  parameter int KINDS     = sakq_pkg::KINDS_DEF,
  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1),
  localparam int KIND_W = (KINDS > 1) ? $clog2(KINDS) : 1,
  localparam int DEPTH  = KINDS * MAX_SLOTS,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire logic [KIND_W-1:0]    load_kind_i,
  input  wire sakq_pkg::q_op_t      op_i,
  input  wire logic [SLOT_W-1:0]    push_slot_i,
  output logic      [SLOT_W-1:0]    front_slot_o,
  output sakq_pkg::q_stat_t         stat_o
);

  logic [SLOT_W-1:0] head_q  [KINDS];
  logic [SLOT_W-1:0] tail_q  [KINDS];
  logic [CNT_W-1:0]  count_q [KINDS];

  logic [SLOT_W-1:0] cur_head_q, cur_tail_q;
  logic [CNT_W-1:0]  cur_count_q;
  logic [KIND_W-1:0] kind_q;

  logic [SLOT_W-1:0] head_next, tail_next;
  logic [ADDR_W-1:0] raddr, waddr;

  assign head_next = (cur_head_q == SLOT_W'(MAX_SLOTS - 1)) ? '0 : cur_head_q + SLOT_W'(1);
  assign tail_next = (cur_tail_q == SLOT_W'(MAX_SLOTS - 1)) ? '0 : cur_tail_q + SLOT_W'(1);

  assign raddr = ADDR_W'(load_kind_i) * ADDR_W'(MAX_SLOTS) + ADDR_W'(head_q[load_kind_i]);
  assign waddr = ADDR_W'(kind_q) * ADDR_W'(MAX_SLOTS) + ADDR_W'(cur_tail_q);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cur_head_q  <= head_q[load_kind_i];
      cur_tail_q  <= tail_q[load_kind_i];
      cur_count_q <= count_q[load_kind_i];
      kind_q      <= load_kind_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KINDS; k++) begin
        head_q[k]  <= '0;
        tail_q[k]  <= '0;
        count_q[k] <= '0;
      end
    end else begin
      if (op_i.push) begin
        tail_q[kind_q]  <= tail_next;
        count_q[kind_q] <= cur_count_q + CNT_W'(1);
      end else if (op_i.pop) begin
        head_q[kind_q]  <= head_next;
        count_q[kind_q] <= cur_count_q - CNT_W'(1);
      end
    end
  end

  assign stat_o.empty = (cur_count_q == '0);
  assign stat_o.full  = (cur_count_q == CNT_W'(MAX_SLOTS));

  sakq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (op_i.push),
    .waddr_i (waddr),
    .wdata_i (push_slot_i),
    .re_i    (load_i),
    .raddr_i (raddr),
    .rdata_o (front_slot_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/slot_allocator_with_kind_queues_core.sv
// Top level of the slot allocator with one slot queue per item kind.
// Depends on sakq_pkg, sakq_free_map, sakq_queues and the defines header.
//
//   Port group     Direction  Handshake            Payload
//   in_*           input      in_valid_i/in_ready_o  sakq_pkg::in_t
//   out_*          output     out_valid_o/out_ready_i sakq_pkg::out_t
//   cfg_*          input      cfg_we_i              slots in use, 4 bits
//
// A transaction is accepted in the idle state, which also reads the queue RAM; the
// execute state updates the free map and pointers and loads the output register.
// The block holds one transaction at a time, so it takes no new one until it commits.
// The execute state follows from the registered read of the queue RAM.
// A full output register stalls the update cycle until the result is taken.
// Reset frees every slot and empties every queue; the queue RAM is not cleared.
`default_nettype none
`include "slot_allocator_with_kind_queues_core_defines.svh"

module slot_allocator_with_kind_queues_core #(
  parameter int MAX_SLOTS = sakq_pkg::MAX_SLOTS_DEF,
  parameter int KINDS     = sakq_pkg::KINDS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire sakq_pkg::in_t              in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output sakq_pkg::out_t                  out_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [sakq_pkg::CFG_W-1:0] cfg_wdata_i
);

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int KIND_W = (KINDS > 1) ? $clog2(KINDS) : 1;
  localparam int SOW    = sakq_pkg::SLOT_OUT_W;
  localparam int COW    = sakq_pkg::COUNT_OUT_W;

  sakq_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0] n_active_q;

  logic             kind_ok_q;
  sakq_pkg::cmd_e   cmd_q;
  logic [1:0]       kind_q;
  logic             exh_q;

  logic             out_valid_q;
  sakq_pkg::out_t   out_data_q;
  sakq_pkg::out_t   result;

  logic             accept, commit, in_kind_ok;
  logic [KIND_W-1:0] load_kind;
  logic             add_ok, use_ok, freed;

  sakq_pkg::fm_op_t  fm_op;
  sakq_pkg::q_op_t   q_op;
  sakq_pkg::q_stat_t q_stat;
  logic              found;
  logic [SLOT_W-1:0] first_slot, front_slot;
  logic [CNT_W-1:0]  free_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_active_q <= CNT_W'(MAX_SLOTS);
    end else if (cfg_we_i) begin
      n_active_q <= (int'(cfg_wdata_i) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(cfg_wdata_i);
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    commit     = 1'b0;
    case (state_q)
      sakq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = sakq_pkg::ST_EXEC;
        end
      end
      sakq_pkg::ST_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          commit  = 1'b1;
          state_d = sakq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sakq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sakq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign accept     = in_valid_i && in_ready_o;
  assign in_kind_ok = int'(in_data_i.kind) < KINDS;
  assign load_kind  = in_kind_ok ? KIND_W'(in_data_i.kind) : '0;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_ok_q <= in_kind_ok;
      cmd_q     <= in_data_i.cmd;
      kind_q    <= in_data_i.kind;
      exh_q     <= in_data_i.front_exhausted;
    end
  end

  assign add_ok = kind_ok_q && (cmd_q == sakq_pkg::CMD_ADD) && found && !q_stat.full;
  assign use_ok = kind_ok_q && (cmd_q == sakq_pkg::CMD_USE) && !q_stat.empty;
  assign freed  = use_ok && ((kind_q != sakq_pkg::KIND_REUSABLE) || exh_q);

  assign fm_op.take      = commit && add_ok;
  assign fm_op.give_back = commit && freed;
  assign q_op.push       = commit && add_ok;
  assign q_op.pop        = commit && freed;

  always_comb begin
    result.ok         = add_ok || use_ok;
    result.slot_freed = freed;
    result.free_count = COW'(free_count);
    if (add_ok) begin
      result.slot = SOW'(first_slot);
    end else if (use_ok) begin
      result.slot = SOW'(front_slot);
    end else begin
      result.slot = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  sakq_free_map #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_free_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .n_active_i   (n_active_q),
    .op_i         (fm_op),
    .give_slot_i  (front_slot),
    .found_o      (found),
    .first_slot_o (first_slot),
    .free_count_o (free_count)
  );

  sakq_queues #(
    .MAX_SLOTS (MAX_SLOTS),
    .KINDS     (KINDS)
  ) u_queues (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .load_kind_i  (load_kind),
    .op_i         (q_op),
    .push_slot_i  (first_slot),
    .front_slot_o (front_slot),
    .stat_o       (q_stat)
  );

  `SAKQ_ASSERT(a_one_in_flight, accept |=> !in_ready_o, "transaction accepted while busy")
  `SAKQ_ASSERT(a_load_from_exec, commit |=> (out_valid_o && state_q == sakq_pkg::ST_IDLE),
               "result not loaded on commit")
  `SAKQ_ASSERT(a_fail_zero_slot, (out_valid_o && !out_data_o.ok) |->
               (out_data_o.slot == '0 && !out_data_o.slot_freed), "failed result carries a slot")
  `SAKQ_ASSERT(a_count_bound, out_valid_o |-> (CNT_W'(out_data_o.free_count) <= n_active_q),
               "free count exceeds slots in use")
  `SAKQ_ASSERT_NEVER(a_push_pop, q_op.push && q_op.pop, "queue push and pop together")

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for slot_allocator_with_kind_queues_core.
// Depends on sakq_pkg; predicts every transaction and compares results in order.
`timescale 1ns / 1ps

module tb_top;

  localparam int HOLD_CYCLES = 150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sakq_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  sakq_pkg::out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [sakq_pkg::CFG_W-1:0] cfg_wdata_i = '0;

  sakq_pkg::in_t requests_pending[$];
  sakq_pkg::out_t alloc_results_due[$];
  int requests_issued = 0;
  int results_seen = 0;
  int fail_count = 0;
  int send_wait = 0;
  int send_calm = 0;
  int recv_wait = 0;
  int recv_calm = 0;
  sakq_pkg::out_t want_res;

  logic [sakq_pkg::MAX_SLOTS_DEF-1:0] free_slots = '1;
  logic [sakq_pkg::CFG_W-1:0] slots_cfg = sakq_pkg::CFG_W'(sakq_pkg::MAX_SLOTS_DEF);
  logic [sakq_pkg::SLOT_OUT_W-1:0] slot_ring[sakq_pkg::KINDS_DEF][sakq_pkg::MAX_SLOTS_DEF];
  int ring_head[sakq_pkg::KINDS_DEF] = '{default: 0};
  int ring_tail[sakq_pkg::KINDS_DEF] = '{default: 0};
  int ring_count[sakq_pkg::KINDS_DEF] = '{default: 0};

  slot_allocator_with_kind_queues_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int draw_idle(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = 30;
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic sakq_pkg::out_t predict_alloc(sakq_pkg::in_t req);
    sakq_pkg::out_t res;
    int lim;
    int pick;
    int k;
    int s;
    int cnt;
    res = '0;
    k = req.kind;
    lim = (slots_cfg > sakq_pkg::MAX_SLOTS_DEF) ? sakq_pkg::MAX_SLOTS_DEF : int'(slots_cfg);
    if (k < sakq_pkg::KINDS_DEF) begin
      if (req.cmd == sakq_pkg::CMD_ADD) begin
        pick = -1;
        for (int i = 0; i < lim; i++) begin
          if (free_slots[i] && pick < 0) pick = i;
        end
        if (pick >= 0 && ring_count[k] < sakq_pkg::MAX_SLOTS_DEF) begin
          slot_ring[k][ring_tail[k]] = sakq_pkg::SLOT_OUT_W'(pick);
          ring_tail[k] = (ring_tail[k] + 1) % sakq_pkg::MAX_SLOTS_DEF;
          ring_count[k]++;
          free_slots[pick] = 1'b0;
          res.ok = 1'b1;
          res.slot = sakq_pkg::SLOT_OUT_W'(pick);
        end
      end else if (ring_count[k] != 0) begin
        s = slot_ring[k][ring_head[k]];
        res.ok = 1'b1;
        res.slot = sakq_pkg::SLOT_OUT_W'(s);
        if (k != int'(sakq_pkg::KIND_REUSABLE) || req.front_exhausted) begin
          free_slots[s] = 1'b1;
          ring_head[k] = (ring_head[k] + 1) % sakq_pkg::MAX_SLOTS_DEF;
          ring_count[k]--;
          res.slot_freed = 1'b1;
        end
      end
    end
    cnt = 0;
    for (int i = 0; i < lim; i++) begin
      if (free_slots[i]) cnt++;
    end
    res.free_count = sakq_pkg::COUNT_OUT_W'(cnt);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        alloc_results_due.push_back(predict_alloc(in_data_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid_i <= 1'b0;
        end else if (requests_pending.size() != 0) begin
          in_data_i <= requests_pending.pop_front();
          in_valid_i <= 1'b1;
          send_wait = draw_idle(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (alloc_results_due.size() == 0) begin
          $error("unexpected transaction: ok %0d slot %0d", out_data_o.ok, out_data_o.slot);
          fail_count++;
        end else begin
          want_res = alloc_results_due.pop_front();
          if (out_data_o.ok !== want_res.ok) begin
            $error("ok: expected %0d actual %0d", want_res.ok, out_data_o.ok);
            fail_count++;
          end
          if (out_data_o.slot !== want_res.slot) begin
            $error("slot: expected %0d actual %0d", want_res.slot, out_data_o.slot);
            fail_count++;
          end
          if (out_data_o.slot_freed !== want_res.slot_freed) begin
            $error("slot_freed: expected %0d actual %0d", want_res.slot_freed,
                   out_data_o.slot_freed);
            fail_count++;
          end
          if (out_data_o.free_count !== want_res.free_count) begin
            $error("free_count: expected %0d actual %0d", want_res.free_count,
                   out_data_o.free_count);
            fail_count++;
          end
        end
        results_seen++;
        if (results_seen == 300 || results_seen == 1000) recv_wait = HOLD_CYCLES;
        else recv_wait = draw_idle(recv_calm);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_ready_i <= (recv_wait == 0);
    end
  end

  task automatic push_req(input sakq_pkg::cmd_e cmd, input int kind, input logic exhausted);
    sakq_pkg::in_t req;
    req.cmd = cmd;
    req.kind = 2'(kind);
    req.front_exhausted = exhausted;
    requests_pending.push_back(req);
    requests_issued++;
  endtask

  task automatic push_random(input int n, input int add_pct);
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = ($urandom_range(0, 15) == 0) ? 3 : $urandom_range(0, 2);
      push_req(($urandom_range(0, 99) < add_pct) ? sakq_pkg::CMD_ADD : sakq_pkg::CMD_USE,
               kind, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_drained();
    while (results_seen != requests_issued) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_slots(input logic [sakq_pkg::CFG_W-1:0] value);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    slots_cfg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < 3; k++) push_req(sakq_pkg::CMD_USE, k, 1'b1);
    push_req(sakq_pkg::CMD_ADD, 3, 1'b1);
    push_req(sakq_pkg::CMD_USE, 3, 1'b0);
    for (int k = 0; k < 3; k++) push_req(sakq_pkg::CMD_ADD, k, 1'b0);
    push_req(sakq_pkg::CMD_USE, 0, 1'b0);
    push_req(sakq_pkg::CMD_USE, 1, 1'b1);
    push_req(sakq_pkg::CMD_USE, 2, 1'b0);
    for (int i = 0; i < 7; i++) push_req(sakq_pkg::CMD_ADD, 1, 1'b0);
    push_req(sakq_pkg::CMD_ADD, 2, 1'b0);
    push_req(sakq_pkg::CMD_USE, 0, 1'b1);

    write_slots(4'd0);
    push_req(sakq_pkg::CMD_ADD, 0, 1'b0);
    push_req(sakq_pkg::CMD_USE, 1, 1'b0);
    push_req(sakq_pkg::CMD_ADD, 1, 1'b1);
    push_req(sakq_pkg::CMD_USE, 1, 1'b1);
    push_req(sakq_pkg::CMD_ADD, 2, 1'b0);
    push_req(sakq_pkg::CMD_USE, 3, 1'b1);

    write_slots(4'd15);
    push_random(250, 55);
    write_slots(4'd1);
    push_random(200, 50);
    write_slots(4'd3);
    push_random(250, 50);
    write_slots(4'd8);
    push_random(150, 75);
    push_random(150, 25);
    for (int p = 0; p < 3; p++) begin
      write_slots(4'($urandom_range(0, 15)));
      push_random(120, $urandom_range(30, 70));
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && alloc_results_due.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
